// ----- hw/rtl/cca_pkg.sv -----
`timescale 1ns / 1ps
// shared codes, field widths and the result record of the cluster chain allocator
// no dependencies

package cca_pkg;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	// request commands
	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// result status
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SHORT = 2'd1;
	localparam logic [1:0] STAT_BAD   = 2'd2;

	// link table entry kinds
	localparam logic [1:0] KIND_EMPTY    = 2'd0;
	localparam logic [1:0] KIND_END      = 2'd1;
	localparam logic [1:0] KIND_RESERVED = 2'd2;
	localparam logic [1:0] KIND_LINK     = 2'd3;

	localparam logic [7:0] MAX_CHAIN = 8'd255;

	// packed so that status lands in the lowest bits of tdata
	typedef struct packed {
		logic [9:0] freed_total;
		logic       is_empty;
		logic       is_end;
		logic [8:0] link_target;
		logic [8:0] first_cluster;
		logic [1:0] status;
	} res_t;

endpackage

// ----- hw/rtl/cluster_chain_allocator.sv -----
`timescale 1ns / 1ps
// cluster chain allocator: link table in one synchronous memory, command sequencer
// depends on cca_pkg

// channel | dir | tdata fields (lowest bit first)
// s_*     | in  | cmd[1:0] cluster[10:2] count[18:11], zero pad to 24 bits
// m_*     | out | status[1:0] first_cluster[10:2] link_target[19:11] is_end[20]
//         |     | is_empty[21] freed_total[31:22]
//
// one request at a time; the result goes to an output register, so the next
// request is taken while an earlier result still waits
// allocate: scan of entries 0 up to the last one taken (one read a cycle, pipelined),
//   then a second pass over the same range to link
// free: walks the chain entry by entry (read data feeds the next address directly)
// lookup: a single table read; bad requests go straight to the response state
// after reset a clearing pass writes every table entry; s_tready stays low
// a stalled result holds the sequencer in its response state

module cluster_chain_allocator #(
	parameter int TABLE_ENTRIES = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cca_pkg::IN_TDATA_W-1:0] s_tdata,   // cmd[1:0] cluster[10:2] count[18:11]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status first_cluster link_target is_end is_empty freed_total
	output logic [cca_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int PW = IW + 1;
	localparam int FW = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_LEND = 3'd4;
	localparam logic [2:0] S_FREE = 3'd5;
	localparam logic [2:0] S_LOOK = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	// result of a request refused at once
	localparam cca_pkg::res_t RES_BAD = cca_pkg::res_t'({30'd0, cca_pkg::STAT_BAD});

	typedef struct packed {
		logic [1:0]    kind;
		logic [IW-1:0] nxt;
	} entry_t;

	// sequencer state
	logic [2:0]     state_q;
	logic [IW-1:0]  clr_q;
	logic [PW-1:0]  ptr_q;        // next address to read in scan and link passes
	logic [PW-1:0]  lim_q;        // end of the current pass
	logic [7:0]     found_q;
	logic [7:0]     count_q;
	logic [IW-1:0]  cur_q;        // start entry for free and lookup
	logic           go_q;         // issue the first read of free or lookup
	logic [IW-1:0]  prev_q;       // last empty entry seen while linking
	logic           have_prev_q;
	logic [IW-1:0]  first_q;
	logic [FW-1:0]  freed_q;
	cca_pkg::res_t  res_q;
	cca_pkg::res_t  out_q;
	logic           m_tvalid_q;

	// table and its read stage
	entry_t         mem [TABLE_ENTRIES];
	entry_t         rdata_s1;
	entry_t         fwd_data_s1;
	logic           fwd_s1;
	logic           rv_s1;
	logic [IW-1:0]  ra_s1;

	logic           rd_en;
	logic [IW-1:0]  rd_addr;
	logic           wr_en;
	logic [IW-1:0]  wr_addr;
	entry_t         wr_data;

	entry_t         ent;
	logic           acc;
	logic [1:0]     in_cmd;
	logic [8:0]     in_cluster;
	logic [7:0]     in_count;
	logic           in_range;
	logic           scan_hit;
	logic           scan_last;
	logic [FW-1:0]  freed_n;
	logic           free_go_on;

	assign in_cmd     = s_tdata[1:0];
	assign in_cluster = s_tdata[10:2];
	assign in_count   = s_tdata[18:11];
	assign in_range   = 32'(in_cluster) < TABLE_ENTRIES;

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// a read that hit the entry written in the same cycle sees the new value
	assign ent = fwd_s1 ? fwd_data_s1 : rdata_s1;

	// scan reaches the requested number of empty entries
	assign scan_hit  = rv_s1 && (ent.kind == cca_pkg::KIND_EMPTY) &&
		((found_q + 8'd1) == count_q);
	assign scan_last = (ra_s1 == IW'(TABLE_ENTRIES - 1));

	// free keeps walking on a link unless the step budget is spent
	assign freed_n    = freed_q + FW'(1);
	assign free_go_on = rv_s1 && (ent.kind == cca_pkg::KIND_LINK) &&
		(freed_n != FW'(TABLE_ENTRIES));

	// table port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = ra_s1;
		wr_data = '{kind: cca_pkg::KIND_EMPTY, nxt: '0};
		unique case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == IW'(2)) begin
					wr_data.kind = cca_pkg::KIND_END;
				end else if (clr_q < IW'(2)) begin
					wr_data.kind = cca_pkg::KIND_RESERVED;
				end
			end
			S_SCAN: begin
				// no read issued in the cycle the scan ends, so none leaks into the link pass
				rd_en = (ptr_q < lim_q) && !scan_hit;
			end
			S_LINK: begin
				rd_en = (ptr_q < lim_q);
				if (rv_s1 && (ent.kind == cca_pkg::KIND_EMPTY) && have_prev_q) begin
					wr_en   = 1'b1;
					wr_addr = prev_q;
					wr_data = '{kind: cca_pkg::KIND_LINK, nxt: ra_s1};
				end
			end
			S_LEND: begin
				wr_en        = 1'b1;
				wr_addr      = prev_q;
				wr_data.kind = cca_pkg::KIND_END;
			end
			S_FREE: begin
				if (go_q) begin
					rd_en   = 1'b1;
					rd_addr = cur_q;
				end else if (rv_s1 && ((ent.kind == cca_pkg::KIND_END) ||
						(ent.kind == cca_pkg::KIND_LINK))) begin
					wr_en   = 1'b1;
					wr_addr = ra_s1;
					if (free_go_on) begin
						rd_en   = 1'b1;
						rd_addr = ent.nxt;
					end
				end
			end
			S_LOOK: begin
				rd_en   = go_q;
				rd_addr = cur_q;
			end
			default: begin
			end
		endcase
	end

	// link table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		ra_s1       <= rd_addr;
		fwd_data_s1 <= wr_data;
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			ptr_q       <= '0;
			lim_q       <= '0;
			found_q     <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			go_q        <= 1'b0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			first_q     <= '0;
			freed_q     <= '0;
			res_q       <= '0;
			out_q       <= '0;
			m_tvalid_q  <= 1'b0;
			rv_s1       <= 1'b0;
			fwd_s1      <= 1'b0;
		end else begin
			rv_s1  <= rd_en;
			fwd_s1 <= rd_en && wr_en && (rd_addr == wr_addr);
			// first read of a free or lookup follows the accepting edge
			go_q   <= acc && in_range &&
				((in_cmd == cca_pkg::CMD_FREE) || (in_cmd == cca_pkg::CMD_LOOKUP));
			if (rd_en) begin
				ptr_q <= ptr_q + PW'(1);
			end
			// the response state reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != S_RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						freed_q     <= '0;
						found_q     <= '0;
						count_q     <= in_count;
						ptr_q       <= '0;
						lim_q       <= PW'(TABLE_ENTRIES);
						cur_q       <= IW'(in_cluster);
						have_prev_q <= 1'b0;
						unique case (in_cmd) inside
							cca_pkg::CMD_ALLOC: begin
								if ((in_count == 8'd0) || (in_count > cca_pkg::MAX_CHAIN)) begin
									res_q   <= RES_BAD;
									state_q <= S_RESP;
								end else begin
									res_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							cca_pkg::CMD_FREE, cca_pkg::CMD_LOOKUP: begin
								if (in_range) begin
									res_q   <= '0;
									state_q <= (in_cmd == cca_pkg::CMD_FREE) ? S_FREE : S_LOOK;
								end else begin
									res_q   <= RES_BAD;
									state_q <= S_RESP;
								end
							end
							default: begin
								res_q   <= RES_BAD;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						// second pass covers entries 0 up to the last one taken
						lim_q   <= PW'(ra_s1) + PW'(1);
						ptr_q   <= '0;
						state_q <= S_LINK;
					end else if (rv_s1) begin
						if (ent.kind == cca_pkg::KIND_EMPTY) begin
							found_q <= found_q + 8'd1;
						end
						if (scan_last) begin
							res_q.status <= cca_pkg::STAT_SHORT;
							state_q      <= S_RESP;
						end
					end
				end
				S_LINK: begin
					if (rv_s1) begin
						if (ent.kind == cca_pkg::KIND_EMPTY) begin
							if (!have_prev_q) begin
								first_q <= ra_s1;
							end
							prev_q      <= ra_s1;
							have_prev_q <= 1'b1;
						end
						if ((PW'(ra_s1) + PW'(1)) == lim_q) begin
							state_q <= S_LEND;
						end
					end
				end
				S_LEND: begin
					res_q.status        <= cca_pkg::STAT_OK;
					res_q.first_cluster <= 9'(first_q);
					state_q             <= S_RESP;
				end
				S_FREE: begin
					if (rv_s1) begin
						if ((ent.kind == cca_pkg::KIND_EMPTY) ||
								(ent.kind == cca_pkg::KIND_RESERVED)) begin
							res_q.status      <= cca_pkg::STAT_BAD;
							res_q.freed_total <= 10'(freed_q);
							state_q           <= S_RESP;
						end else begin
							freed_q <= freed_n;
							if (ent.kind == cca_pkg::KIND_END) begin
								res_q.status      <= cca_pkg::STAT_OK;
								res_q.freed_total <= 10'(freed_n);
								state_q           <= S_RESP;
							end else if (!free_go_on) begin
								// walk longer than the table
								res_q.status      <= cca_pkg::STAT_BAD;
								res_q.freed_total <= 10'(freed_n);
								state_q           <= S_RESP;
							end
						end
					end
				end
				S_LOOK: begin
					if (rv_s1) begin
						res_q.status      <= cca_pkg::STAT_OK;
						res_q.link_target <= (ent.kind == cca_pkg::KIND_LINK) ? 9'(ent.nxt) : 9'd0;
						res_q.is_end      <= (ent.kind == cca_pkg::KIND_END);
						res_q.is_empty    <= (ent.kind == cca_pkg::KIND_EMPTY);
						state_q           <= S_RESP;
					end
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						out_q      <= res_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/cca_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the cluster chain allocator, bound to the top level
// depends on cca_pkg and cluster_chain_allocator

module cca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	logic [1:0] pend_q;
	logic       s_acc;
	logic       m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// requests taken whose result is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(s_acc) - 2'(m_acc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == cca_pkg::STAT_OK) || (m_tdata[1:0] == cca_pkg::STAT_SHORT) ||
			(m_tdata[1:0] == cca_pkg::STAT_BAD))
		else $error("unknown status code");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[20] && m_tdata[21]))
		else $error("entry both end and empty");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc |-> pend_q != 2'd0)
		else $error("result without request");

	a_one_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> pend_q <= 2'd1)
		else $error("request taken with two results pending");

endmodule

bind cluster_chain_allocator cca_checker u_cca_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- bench/tb_cluster_chain_allocator.sv -----
`timescale 1ns / 1ps
// self-checking bench for the cluster chain allocator: directed corner requests, then random
// allocate/free/lookup traffic under varying backpressure; depends on cca_pkg and the dut

module tb_cluster_chain_allocator;

	localparam int ENTRIES = 512;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
	localparam int RANDOM_PER_PHASE = 150;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// shadow of the link table plus the queue of results still owed by the dut
	class link_table_tracker;
		logic [1:0] entry_kind [ENTRIES];
		logic [8:0] entry_next [ENTRIES];
		cca_pkg::res_t owed_results [$];
		int fails;
		int n_alloc_ok, n_short, n_free_ok, n_bad, n_lookup;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				entry_kind[i] = cca_pkg::KIND_EMPTY;
				entry_next[i] = '0;
			end
			entry_kind[0] = cca_pkg::KIND_RESERVED;
			entry_kind[1] = cca_pkg::KIND_RESERVED;
			entry_kind[2] = cca_pkg::KIND_END;
			fails = 0;
			n_alloc_ok = 0;
			n_short = 0;
			n_free_ok = 0;
			n_bad = 0;
			n_lookup = 0;
		endfunction

		// applies one request to the shadow table and returns the result it must produce
		function cca_pkg::res_t note_request(logic [1:0] cmd, logic [8:0] cl, logic [7:0] cnt);
			cca_pkg::res_t r;
			int found, limit, prev, cur, freed;
			bit have_prev, done;
			logic [1:0] k;
			logic [8:0] nx;
			r = '0;
			case (cmd)
				cca_pkg::CMD_ALLOC: begin
					if (cnt == 0 || cnt > cca_pkg::MAX_CHAIN) begin
						r.status = cca_pkg::STAT_BAD;
					end else begin
						found = 0;
						limit = 0;
						while (found < cnt && limit < ENTRIES) begin
							if (entry_kind[limit] == cca_pkg::KIND_EMPTY)
								found++;
							limit++;
						end
						if (found < cnt) begin
							r.status = cca_pkg::STAT_SHORT;
						end else begin
							// link the empty entries below the scan limit in ascending order
							have_prev = 0;
							prev = 0;
							for (int i = 0; i < limit; i++) begin
								if (entry_kind[i] == cca_pkg::KIND_EMPTY) begin
									if (have_prev) begin
										entry_kind[prev] = cca_pkg::KIND_LINK;
										entry_next[prev] = i[8:0];
									end else begin
										r.first_cluster = i[8:0];
									end
									prev = i;
									have_prev = 1;
								end
							end
							entry_kind[prev] = cca_pkg::KIND_END;
							entry_next[prev] = '0;
							r.status = cca_pkg::STAT_OK;
						end
					end
				end
				cca_pkg::CMD_FREE: begin
					cur = cl;
					freed = 0;
					done = 0;
					r.status = cca_pkg::STAT_BAD;
					while (!done && freed < ENTRIES) begin
						k = entry_kind[cur];
						nx = entry_next[cur];
						if (k == cca_pkg::KIND_EMPTY || k == cca_pkg::KIND_RESERVED) begin
							done = 1;
						end else begin
							entry_kind[cur] = cca_pkg::KIND_EMPTY;
							entry_next[cur] = '0;
							freed++;
							if (k == cca_pkg::KIND_END) begin
								r.status = cca_pkg::STAT_OK;
								done = 1;
							end else begin
								cur = nx;
							end
						end
					end
					r.freed_total = freed[9:0];
				end
				cca_pkg::CMD_LOOKUP: begin
					k = entry_kind[cl];
					r.status = cca_pkg::STAT_OK;
					if (k == cca_pkg::KIND_LINK)
						r.link_target = entry_next[cl];
					r.is_end = (k == cca_pkg::KIND_END);
					r.is_empty = (k == cca_pkg::KIND_EMPTY);
					n_lookup++;
				end
				default: r.status = cca_pkg::STAT_BAD;
			endcase
			if (cmd == cca_pkg::CMD_ALLOC && r.status == cca_pkg::STAT_OK)
				n_alloc_ok++;
			if (cmd == cca_pkg::CMD_FREE && r.status == cca_pkg::STAT_OK)
				n_free_ok++;
			if (r.status == cca_pkg::STAT_SHORT)
				n_short++;
			if (r.status == cca_pkg::STAT_BAD)
				n_bad++;
			owed_results.push_back(r);
			return r;
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				fails++;
			end
		endfunction

		function void check_result(logic [31:0] data);
			cca_pkg::res_t got, want;
			got = data;
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got 0x%08h", $time, data);
				fails++;
			end else begin
				want = owed_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("first_cluster", want.first_cluster, got.first_cluster);
				check_field("link_target", want.link_target, got.link_target);
				check_field("is_end", want.is_end, got.is_end);
				check_field("is_empty", want.is_empty, got.is_empty);
				check_field("freed_total", want.freed_total, got.freed_total);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;     // cmd[1:0] cluster[10:2] count[18:11]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // status first_cluster link_target is_end is_empty freed_total

	link_table_tracker tracker = new();
	logic [8:0] live_heads [$];    // chain heads handed out by successful allocations
	int tx_idle_pct = 9;
	int rx_idle_pct = 49;
	int quiet_cycles = 0;
	int n_requests = 0;

	cluster_chain_allocator #(
		.TABLE_ENTRIES(ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// result side: random backpressure, checked at the rising edge
	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// offers one request, with random gaps ahead of it, until the dut takes it
	task automatic send_request(input logic [1:0] cmd, input logic [8:0] cl,
			input logic [7:0] cnt);
		cca_pkg::res_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {5'b0, cnt, cl, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		r = tracker.note_request(cmd, cl, cnt);
		n_requests++;
		if (cmd == cca_pkg::CMD_ALLOC && r.status == cca_pkg::STAT_OK)
			live_heads.push_back(r.first_cluster);
	endtask

	// stop offering and hold off until every owed result has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (tracker.owed_results.size() != 0)
			@(posedge clk);
	endtask

	// mostly well-formed traffic: small allocations and frees of known chain heads
	task automatic run_random(input int n);
		int r, r2, idx;
		logic [1:0] cmd;
		logic [8:0] cl;
		logic [7:0] cnt;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			r2 = $urandom_range(0, 99);
			cl = 9'($urandom_range(0, ENTRIES - 1));
			cnt = 8'($urandom_range(0, 255));
			if (r < 38) begin
				cmd = cca_pkg::CMD_ALLOC;
				if (r2 < 88)
					cnt = 8'($urandom_range(1, 12));
				else if (r2 < 97)
					cnt = 8'($urandom_range(13, 255));
				else if (r2 < 99)
					cnt = 8'd0;
				else
					cnt = cca_pkg::MAX_CHAIN;
			end else if (r < 72) begin
				cmd = cca_pkg::CMD_FREE;
				// free a known head most of the time, otherwise anywhere (mid-chain, empty)
				if (live_heads.size() != 0 && (r2 < 75 || (live_heads.size() > 8 && r2 < 92))) begin
					idx = $urandom_range(0, live_heads.size() - 1);
					cl = live_heads[idx];
					live_heads.delete(idx);
				end
			end else if (r < 95) begin
				cmd = cca_pkg::CMD_LOOKUP;
				if (live_heads.size() != 0 && r2 < 40)
					cl = 9'(live_heads[$urandom_range(0, live_heads.size() - 1)]
						+ $urandom_range(0, 3));
			end else begin
				cmd = CMD_UNUSED;
			end
			send_request(cmd, cl, cnt);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// phase 0: corner requests, then random with a slow receiver
		tx_idle_pct = 9;
		rx_idle_pct = 49;
		send_request(cca_pkg::CMD_LOOKUP, 9'd0, 8'd0);      // reserved entry
		send_request(cca_pkg::CMD_LOOKUP, 9'd2, 8'd255);    // root chain end
		send_request(cca_pkg::CMD_LOOKUP, 9'd511, 8'd0);    // empty top entry
		send_request(cca_pkg::CMD_ALLOC, 9'd511, 8'd0);     // zero count
		send_request(CMD_UNUSED, 9'd511, 8'd255);           // unused command code
		send_request(cca_pkg::CMD_FREE, 9'd0, 8'd0);        // free from reserved entry
		send_request(cca_pkg::CMD_FREE, 9'd300, 8'd0);      // free from empty entry
		send_request(cca_pkg::CMD_ALLOC, 9'd0, 8'd1);       // single entry chain at 3
		send_request(cca_pkg::CMD_ALLOC, 9'd0, 8'd255);     // longest chain, 4..258
		send_request(cca_pkg::CMD_ALLOC, 9'd0, 8'd255);     // not enough left
		send_request(cca_pkg::CMD_ALLOC, 9'd0, 8'd253);     // takes the rest up to 511
		send_request(cca_pkg::CMD_LOOKUP, 9'd100, 8'd0);    // link entry
		send_request(cca_pkg::CMD_LOOKUP, 9'd511, 8'd0);    // end at the top
		send_request(cca_pkg::CMD_ALLOC, 9'd0, 8'd1);       // table full
		send_request(cca_pkg::CMD_FREE, 9'd100, 8'd0);      // free from mid-chain
		send_request(cca_pkg::CMD_FREE, 9'd4, 8'd0);        // walk runs into emptied entry
		send_request(cca_pkg::CMD_FREE, 9'd3, 8'd0);
		send_request(cca_pkg::CMD_FREE, 9'd259, 8'd0);
		send_request(cca_pkg::CMD_FREE, 9'd2, 8'd0);        // root chain
		send_request(cca_pkg::CMD_LOOKUP, 9'd2, 8'd0);
		send_request(cca_pkg::CMD_ALLOC, 9'd0, 8'd255);     // reuses the root entry
		send_request(cca_pkg::CMD_FREE, 9'd2, 8'd0);
		live_heads.delete();
		run_random(RANDOM_PER_PHASE);
		wait_drained();

		// phase 1: bursty sender, eager receiver
		tx_idle_pct = 49;
		rx_idle_pct = 9;
		run_random(RANDOM_PER_PHASE);
		wait_drained();

		// phase 2: no idling on either side
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(RANDOM_PER_PHASE);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d allocations ok, %0d short, %0d frees ok, %0d bad, %0d lookups",
			n_requests, tracker.n_alloc_ok, tracker.n_short, tracker.n_free_ok,
			tracker.n_bad, tracker.n_lookup);
		$display("backpressure phases: slow receiver, bursty sender, none; %0d mismatches",
			tracker.fails);
		if (tracker.fails == 0 && tracker.owed_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
